// File: sv/imm_pkg.sv
package imm_pkg;

  // Default sizing of the operand stores
  localparam int MAX_N_DEF     = 16;
  localparam int ELEM_BITS_DEF = 16;

  // Fixed port field widths
  localparam int FUNC_W = 2;
  localparam int IDX_IN_W = 4;
  localparam int VALUE_W = 16;
  localparam int SIZE_W = 5;
  localparam int ACC_W = 32;

  // Matrix size after reset
  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CALC   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

endpackage

// File: sv/integer_matrix_multiply.sv
// Square integer matrix multiply. Load words (func 0 for A, 1 for B) write
// one element and give no result. A compute word (func 2)
// returns C[row][col], the sum over k below n of A[row][k] * B[k][col] wrapped
// to 32 bits, on out_product with out_strobe high for exactly one cycle; the
// receiver cannot stall it. A compute word keeps busy high, and no new word is
// taken, until its result is out: one term per cycle through a single shared
// multiply-accumulate unit, then the registered memory read, the multiplier
// register and the accumulator. n is matrix_size, limited to MAX_N; the user
// must write it through cfg_we / cfg_wdata only while the block is idle; the
// block itself does not enforce this. Row and column indexes wrap modulo
// MAX_N. Reading an element never loaded returns an undefined value.
module integer_matrix_multiply #(
  parameter int MAX_N     = imm_pkg::MAX_N_DEF,
  parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [imm_pkg::FUNC_W-1:0]        in_func,
  input  logic [imm_pkg::IDX_IN_W-1:0]      in_row,
  input  logic [imm_pkg::IDX_IN_W-1:0]      in_col,
  input  logic signed [imm_pkg::VALUE_W-1:0] in_value,
  output logic                              out_strobe,
  output logic signed [imm_pkg::ACC_W-1:0]  out_product,
  input  logic                              cfg_we,
  input  logic [imm_pkg::SIZE_W-1:0]        cfg_wdata
);
  import imm_pkg::*;

  localparam int IDX_W = $clog2(MAX_N);
  localparam int CNT_W = $clog2(MAX_N + 1);
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDX_IN_N = 2 ** IDX_IN_W;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]    matrix_size_r;
  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     kcnt_r;
  logic [IDX_W-1:0]     row_r;
  logic [IDX_W-1:0]     col_r;
  logic [IDX_W-1:0]     wrap_lut [IDX_IN_N];
  logic [IDX_W-1:0]     wr_row;
  logic [IDX_W-1:0]     wr_col;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        a_addr;
  logic [AW-1:0]        b_addr;
  logic [ELEM_BITS-1:0] wr_elem;
  logic [ELEM_BITS-1:0] mem_a [DEPTH];
  logic [ELEM_BITS-1:0] mem_b [DEPTH];
  logic [ELEM_BITS-1:0] rd_a_r;
  logic [ELEM_BITS-1:0] rd_b_r;
  logic                 rd_vld_r;
  logic                 accept;
  logic                 we_a;
  logic                 we_b;
  logic                 calc_go;
  logic                 last_k;
  logic                 issue;
  logic                 pipe_empty;
  logic                 out_strobe_nxt;
  logic                 out_strobe_r;
  logic [ACC_W-1:0]     out_product_r;
  logic                 mac_busy;
  logic [ACC_W-1:0]     mac_acc;
  mac_ctrl_t            mac_ctrl;

  // Build the index wrap table at elaboration
  for (genvar g = 0; g < IDX_IN_N; g++) begin : g_wrap
    localparam int WrapVal = g % MAX_N;
    assign wrap_lut[g] = IDX_W'(WrapVal);
  end

  // Decode the incoming word
  assign accept = start && !busy;
  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    calc_go = 1'b0;
    unique case (in_func)
      FUNC_LOAD_A: we_a    = accept;
      FUNC_LOAD_B: we_b    = accept;
      FUNC_CALC:   calc_go = accept;
      default: ;
    endcase
  end

  assign wr_row  = wrap_lut[in_row];
  assign wr_col  = wrap_lut[in_col];
  assign wr_addr = AW'(AW'(wr_row) * AW'(MAX_N) + AW'(wr_col));
  assign wr_elem = ELEM_BITS'(in_value);

  // Limit the size to what the stores hold
  assign n_eff = (int'(matrix_size_r) > MAX_N) ? CNT_W'(MAX_N) : CNT_W'(matrix_size_r);
  assign last_k = ((kcnt_r + CNT_W'(1)) == n_eff);

  assign a_addr = AW'(AW'(row_r) * AW'(MAX_N) + AW'(kcnt_r[IDX_W-1:0]));
  assign b_addr = AW'(AW'(kcnt_r[IDX_W-1:0]) * AW'(MAX_N) + AW'(col_r));

  assign pipe_empty = !rd_vld_r && !mac_busy;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= SIZE_RST;
    end else if (cfg_we) begin
      matrix_size_r <= cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (calc_go) begin
          state_nxt = (n_eff == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    issue          = 1'b0;
    out_strobe_nxt = 1'b0;
    mac_ctrl.clr   = 1'b0;
    mac_ctrl.vld   = rd_vld_r;
    unique case (state_r)
      ST_IDLE:  mac_ctrl.clr   = calc_go;
      ST_RUN:   issue          = 1'b1;
      ST_DRAIN: out_strobe_nxt = pipe_empty;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= issue;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Capture indexes and advance the term counter
  always_ff @(posedge clk) begin
    if (calc_go) begin
      row_r  <= wr_row;
      col_r  <= wr_col;
      kcnt_r <= '0;
    end else if (issue) begin
      kcnt_r <= kcnt_r + CNT_W'(1);
    end
  end

  // Operand stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_elem;
    end
    rd_a_r <= mem_a[a_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_elem;
    end
    rd_b_r <= mem_b[b_addr];
  end

  imm_mac #(
    .ELEM_W(ELEM_BITS)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (mac_ctrl),
    .a    (rd_a_r),
    .b    (rd_b_r),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  // Hold the finished sum for its strobe cycle
  always_ff @(posedge clk) begin
    if (out_strobe_nxt) begin
      out_product_r <= mac_acc;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_strobe  = out_strobe_r;
  assign out_product = out_product_r;

  // A result never lasts more than one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held two cycles");

  // A result only follows a drained pipeline
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_DRAIN))
    else $error("result without drain");

  // An accepted compute word makes the block busy
  a_calc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_CALC)) |=> busy)
    else $error("compute word did not start");

  // No read is in flight while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_vld_r && !mac_busy))
    else $error("work in flight while idle");

endmodule

// File: sv/imm_mac.sv
module imm_mac #(
  parameter int ELEM_W = imm_pkg::ELEM_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  imm_pkg::mac_ctrl_t        ctrl,
  input  logic [ELEM_W-1:0]         a,
  input  logic [ELEM_W-1:0]         b,
  output logic                      busy,
  output logic [imm_pkg::ACC_W-1:0] acc
);
  import imm_pkg::*;

  logic [ACC_W-1:0] a_ext;
  logic [ACC_W-1:0] b_ext;
  logic [ACC_W-1:0] prod_r;
  logic             prod_vld_r;
  logic [ACC_W-1:0] acc_r;

  // Sign-extend the stored elements; only the low word of the product matters
  assign a_ext = ACC_W'($signed(a));
  assign b_ext = ACC_W'($signed(b));

  // Multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (ctrl.clr) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_ext * b_ext;
  end

  // Accumulate stage, wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign busy = prod_vld_r;
  assign acc  = acc_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import imm_pkg::*;

  localparam int MAX_N = MAX_N_DEF;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One command word as queued for the driver
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [IDX_IN_W-1:0] row;
    logic [IDX_IN_W-1:0] col;
    logic signed [VALUE_W-1:0] value;
    bit drain;
  } mm_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [IDX_IN_W-1:0] in_row = '0;
  logic [IDX_IN_W-1:0] in_col = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic out_strobe;
  logic signed [ACC_W-1:0] out_product;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // Pending command words and products still owed by the block
  mm_word_t word_q[$];
  logic signed [ACC_W-1:0] product_q[$];

  // Predictor copy of the operand stores and the size register
  logic signed [VALUE_W-1:0] mat_a[MAX_N*MAX_N];
  logic signed [VALUE_W-1:0] mat_b[MAX_N*MAX_N];
  logic [SIZE_W-1:0] cur_size = SIZE_RST;

  // Entries the generator has loaded so far
  bit seen_a[MAX_N*MAX_N];
  bit seen_b[MAX_N*MAX_N];

  int idle_pct = 0;
  int queued = 0;
  int mismatches = 0;
  int cycles = 0;
  int n_loads = 0;
  int n_calcs = 0;
  int n_unused = 0;
  int n_checked = 0;

  integer_matrix_multiply uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_product(out_product),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Update the stores or work out C[row][col] for one accepted word
  task automatic apply_word(logic [FUNC_W-1:0] f, logic [IDX_IN_W-1:0] r,
                            logic [IDX_IN_W-1:0] c, logic signed [VALUE_W-1:0] v);
    int acc;
    int n;
    case (f)
      FUNC_LOAD_A: begin
        mat_a[r*MAX_N + c] = v;
        n_loads++;
      end
      FUNC_LOAD_B: begin
        mat_b[r*MAX_N + c] = v;
        n_loads++;
      end
      FUNC_CALC: begin
        n = (cur_size > MAX_N) ? MAX_N : cur_size;
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += int'(mat_a[r*MAX_N + k]) * int'(mat_b[k*MAX_N + c]);
        end
        product_q.push_back(acc);
        n_calcs++;
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic queue_word(logic [FUNC_W-1:0] f, logic [IDX_IN_W-1:0] r,
                            logic [IDX_IN_W-1:0] c, logic signed [VALUE_W-1:0] v,
                            bit drain = 1'b0);
    mm_word_t w;
    w.func = f;
    w.row = r;
    w.col = c;
    w.value = v;
    w.drain = drain;
    word_q.push_back(w);
    queued++;
  endtask

  task automatic queue_load(bit to_b, logic [IDX_IN_W-1:0] r, logic [IDX_IN_W-1:0] c,
                            logic signed [VALUE_W-1:0] v);
    queue_word(to_b ? FUNC_LOAD_B : FUNC_LOAD_A, r, c, v);
    if (to_b) seen_b[r*MAX_N + c] = 1'b1;
    else seen_a[r*MAX_N + c] = 1'b1;
  endtask

  // Load whatever the request would read that was never written, then ask
  task automatic queue_product(logic [IDX_IN_W-1:0] r, logic [IDX_IN_W-1:0] c, int eff,
                               bit drain = 1'b0);
    for (int k = 0; k < eff; k++) begin
      if (!seen_a[r*MAX_N + k]) queue_load(1'b0, r, IDX_IN_W'(k), rand_elem());
      if (!seen_b[k*MAX_N + c]) queue_load(1'b1, IDX_IN_W'(k), c, rand_elem());
    end
    queue_word(FUNC_CALC, r, c, VALUE_W'($urandom), drain);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every word is taken and every product is back, then let it idle
  task automatic settle();
    while (word_q.size() != 0 || product_q.size() != 0 || start) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(logic [SIZE_W-1:0] sz, int pct, int count);
    int stop;
    int pick;
    int eff;
    eff = (sz > MAX_N) ? MAX_N : sz;
    write_size(sz);
    idle_pct = pct;
    stop = queued + count;
    while (queued < stop) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        queue_product(IDX_IN_W'($urandom_range(15)), IDX_IN_W'($urandom_range(15)), eff,
                      $urandom_range(39) == 0);
      end else if (pick < 94) begin
        queue_load(1'($urandom_range(1)), IDX_IN_W'($urandom_range(15)),
                   IDX_IN_W'($urandom_range(15)), rand_elem());
      end else begin
        queue_word(FUNC_UNUSED, IDX_IN_W'($urandom_range(15)), IDX_IN_W'($urandom_range(15)),
                   VALUE_W'($urandom));
      end
    end
    settle();
  endtask

  // Driver: hold a word until taken, then present the next one or idle
  always @(posedge clk) begin : drive_p
    bit drained;
    if (cfg_we) cur_size = cfg_wdata;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      drained = (product_q.size() == 0 || (product_q.size() == 1 && out_strobe)) &&
                !(start && in_func == FUNC_CALC);
      if (start) begin
        apply_word(in_func, in_row, in_col, in_value);
        void'(word_q.pop_front());
      end
      if (word_q.size() != 0 && $urandom_range(99) >= idle_pct &&
          (!word_q[0].drain || drained)) begin
        start <= 1'b1;
        in_func <= word_q[0].func;
        in_row <= word_q[0].row;
        in_col <= word_q[0].col;
        in_value <= word_q[0].value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: match each strobed product against the oldest expectation
  always @(posedge clk) begin : check_p
    logic signed [ACC_W-1:0] want;
    if (rst_n && out_strobe) begin
      if (product_q.size() == 0) begin
        $error("product: nothing expected, got %0d", out_product);
        mismatches++;
      end else begin
        want = product_q.pop_front();
        n_checked++;
        if (out_product !== want) begin
          $error("product: expected %0d, got %0d", want, out_product);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes at size 2, a load outside the active square,
    // the unused selector and a wait for all products
    write_size(5'd2);
    queue_load(1'b0, 0, 0, -16'sd32768);
    queue_load(1'b0, 0, 1, -16'sd32768);
    queue_load(1'b1, 0, 0, -16'sd32768);
    queue_load(1'b1, 1, 0, -16'sd32768);
    queue_product(0, 0, 2);
    queue_load(1'b0, 15, 0, 16'sd32767);
    queue_load(1'b0, 15, 1, 16'sd32767);
    queue_load(1'b1, 0, 15, 16'sd32767);
    queue_load(1'b1, 1, 15, 16'sd32767);
    queue_product(15, 15, 2);
    queue_word(FUNC_UNUSED, 15, 15, -16'sd1);
    queue_product(15, 0, 2, 1'b1);
    queue_load(1'b0, 15, 15, 16'sd1);
    queue_product(0, 15, 2);
    settle();

    // Size zero: empty sum
    write_size(5'd0);
    queue_product(3, 12, 0);
    queue_product(15, 0, 0);
    settle();

    random_phase(5'd1, 0, 240);
    random_phase(5'd31, 49, 240);
    random_phase(5'd16, 31, 240);
    random_phase(5'd5, 0, 240);
    random_phase(5'd2, 49, 240);
    random_phase(5'd16, 0, 240);
    random_phase(5'd12, 31, 240);

    $display("tb_top: %0d words (%0d loads, %0d products, %0d unused selector), %0d checked",
             n_loads + n_calcs + n_unused, n_loads, n_calcs, n_unused, n_checked);
    $display("tb_top: sizes 2, 0, 1, 31, 16, 5, 2, 12 with sender idling at 0, 31 and 49 pct");
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
